// File: hw/rtl/srd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick radial deadzone package
// Shared widths, constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package srd_pkg;

  // Sample format: signed Q1.(SAMPLE_BITS-1).
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // Magnitude and remap values are unsigned Q1.30 (31 bits).
  localparam int ROOT_W     = 31;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DEAD_W     = 16;
  localparam int DEAD_SHIFT = 14;

  // Default number of result bits resolved per pipeline stage.
  localparam int SQRT_STEPS_DEF = 4;
  localparam int DIV_STEPS_DEF  = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DEAD_W;

  localparam logic [ROOT_W-1:0] ONE_Q30 = {1'b1, {(ROOT_W-1){1'b0}}};

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_RADIUS = 2'd0,
    CFG_FLIP_X      = 2'd1,
    CFG_FLIP_Y      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                          pad_present;
    logic signed [SAMPLE_BITS-1:0] raw_y;
    logic signed [SAMPLE_BITS-1:0] raw_x;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic signed [SAMPLE_BITS-1:0] out_x;
  } out_item_t;

endpackage

// File: hw/rtl/srd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit square root of a 2*ROOT_W bit radicand, STEPS result bits
// per stage, with a side tag that travels alongside each transfer.
// ----------------------------------------------------------------------------
module srd_sqrt import srd_pkg::*; #(
  parameter int ROOT_W_P = ROOT_W,
  parameter int STEPS    = SQRT_STEPS_DEF,
  parameter int TAG_W    = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2*ROOT_W_P-1:0] rad_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROOT_W_P-1:0]   root_o,
  output logic [TAG_W-1:0]      tag_o
);

  localparam int RADW   = 2 * ROOT_W_P;
  localparam int REM_W  = ROOT_W_P + 2;
  localparam int STAGES = 1 + (ROOT_W_P + STEPS - 1) / STEPS;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES:0]   en;

  logic [RADW-1:0]     rad_q  [STAGES];
  logic [RADW-1:0]     rad_d  [STAGES];
  logic [REM_W-1:0]    rem_q  [STAGES];
  logic [REM_W-1:0]    rem_d  [STAGES];
  logic [ROOT_W_P-1:0] root_q [STAGES];
  logic [ROOT_W_P-1:0] root_d [STAGES];
  logic [TAG_W-1:0]    tag_q  [STAGES];
  logic [TAG_W-1:0]    tag_d  [STAGES];

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    en[STAGES] = out_ready_i;
    for (int s = STAGES - 1; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign vld_d      = {vld_q[STAGES-2:0], in_valid_i};
  assign in_ready_o = en[0];

  // Stage zero captures the operand; each later stage resolves STEPS root bits.
  always_comb begin
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    acc   = '0;
    trial = '0;
    rad_d[0]  = rad_i;
    rem_d[0]  = '0;
    root_d[0] = '0;
    tag_d[0]  = tag_i;
    for (int s = 1; s < STAGES; s++) begin
      rad_d[s]  = rad_q[s-1];
      rem_d[s]  = rem_q[s-1];
      root_d[s] = root_q[s-1];
      tag_d[s]  = tag_q[s-1];
      for (int k = 0; k < STEPS; k++) begin
        if ((s - 1) * STEPS + k < ROOT_W_P) begin
          acc   = {rem_d[s], rad_d[s][RADW-1 -: 2]};
          trial = {2'b00, root_d[s], 2'b01};
          rad_d[s] = rad_d[s] << 2;
          if (acc >= trial) begin
            rem_d[s]  = REM_W'(acc - trial);
            root_d[s] = {root_d[s][ROOT_W_P-2:0], 1'b1};
          end else begin
            rem_d[s]  = acc[REM_W-1:0];
            root_d[s] = {root_d[s][ROOT_W_P-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_d[s];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s]) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        tag_q[s]  <= tag_d[s];
      end
    end
  end

  assign out_valid_o = vld_q[STAGES-1];
  assign root_o      = root_q[STAGES-1];
  assign tag_o       = tag_q[STAGES-1];

endmodule

// File: hw/rtl/srd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides LANES dividends by one shared divisor, STEPS quotient bits per
// stage. The high part of each dividend must be below the divisor.
// ----------------------------------------------------------------------------
module srd_div import srd_pkg::*; #(
  parameter int LANES = 1,
  parameter int DEN_W = ROOT_W,
  parameter int QW    = ROOT_W - 1,
  parameter int STEPS = DIV_STEPS_DEF,
  parameter int TAG_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [LANES-1:0][DEN_W-1:0] hi_i,
  input  logic [LANES-1:0][QW-1:0]    lo_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LANES-1:0][QW-1:0]    quot_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int AW     = DEN_W + 1 + QW;
  localparam int STAGES = 1 + (QW + STEPS - 1) / STEPS;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES:0]   en;

  // Each lane keeps the partial remainder above the dividend bits still to
  // come; quotient bits shift in from the bottom.
  logic [LANES-1:0][AW-1:0] acc_q [STAGES];
  logic [LANES-1:0][AW-1:0] acc_d [STAGES];
  logic [DEN_W-1:0]         den_q [STAGES];
  logic [DEN_W-1:0]         den_d [STAGES];
  logic [TAG_W-1:0]         tag_q [STAGES];
  logic [TAG_W-1:0]         tag_d [STAGES];

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    en[STAGES] = out_ready_i;
    for (int s = STAGES - 1; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign vld_d      = {vld_q[STAGES-2:0], in_valid_i};
  assign in_ready_o = en[0];

  // Stage zero captures the operands; each later stage does STEPS shift and
  // subtract steps per lane.
  always_comb begin
    logic [DEN_W:0] top;
    top = '0;
    for (int l = 0; l < LANES; l++) begin
      acc_d[0][l] = {1'b0, hi_i[l], lo_i[l]};
    end
    den_d[0] = den_i;
    tag_d[0] = tag_i;
    for (int s = 1; s < STAGES; s++) begin
      acc_d[s] = acc_q[s-1];
      den_d[s] = den_q[s-1];
      tag_d[s] = tag_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < STEPS; k++) begin
          if ((s - 1) * STEPS + k < QW) begin
            acc_d[s][l] = acc_d[s][l] << 1;
            top = acc_d[s][l][AW-1 -: DEN_W+1];
            if (top >= {1'b0, den_d[s]}) begin
              acc_d[s][l][AW-1 -: DEN_W+1] = top - {1'b0, den_d[s]};
              acc_d[s][l][0] = 1'b1;
            end
          end
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_d[s];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s]) begin
        acc_q[s] <= acc_d[s];
        den_q[s] <= den_d[s];
        tag_q[s] <= tag_d[s];
      end
    end
  end

  // Quotients sit in the low bits of each lane.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = acc_q[STAGES-1][l][QW-1:0];
    end
  end

  assign out_valid_o = vld_q[STAGES-1];
  assign tag_o       = tag_q[STAGES-1];

endmodule

// File: hw/rtl/stick_radial_deadzone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick radial deadzone
// Radial deadzone and rescale of one two-axis stick sample, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the output is not stalled and
// returns one result per sample, in order. A sample passes the entry
// register, the pipelined square root, the remap divider, the multiply
// register, the scale divider and the output register. Every stage holds
// its own valid bit, so empty stages fill while the output register waits
// for a transfer. Write the configuration registers only while no sample is
// in flight.
module stick_radial_deadzone import srd_pkg::*; #(
  parameter int SQRT_STEPS = SQRT_STEPS_DEF,
  parameter int DIV_STEPS  = DIV_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int W = SAMPLE_BITS;

  typedef struct packed {
    logic                present;
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
  } sqrt_tag_t;

  typedef struct packed {
    logic                zero;
    logic                sat;
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
  } remap_tag_t;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
  } scale_tag_t;

  // Configuration registers.
  logic [DEAD_W-1:0] dead_q;
  logic              flip_x_q;
  logic              flip_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q   <= '0;
      flip_x_q <= 1'b0;
      flip_y_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEAD_RADIUS: dead_q   <= cfg_wdata_i[DEAD_W-1:0];
        CFG_FLIP_X:      flip_x_q <= cfg_wdata_i[0];
        CFG_FLIP_Y:      flip_y_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Entry stage: optional axis inversion, with minus one going to the
  // largest positive value.
  logic                s0_en;
  logic                s0_vld_q;
  logic signed [W-1:0] s0_x_q, s0_y_q, flip_x_val, flip_y_val;
  logic                s0_pres_q;
  logic                sqrt_in_ready;

  always_comb begin
    flip_x_val = in_item_i.raw_x;
    flip_y_val = in_item_i.raw_y;
    if (flip_x_q) begin
      flip_x_val = (in_item_i.raw_x == SAMPLE_MIN) ? SAMPLE_MAX : -in_item_i.raw_x;
    end
    if (flip_y_q) begin
      flip_y_val = (in_item_i.raw_y == SAMPLE_MIN) ? SAMPLE_MAX : -in_item_i.raw_y;
    end
  end

  assign s0_en      = !s0_vld_q || sqrt_in_ready;
  assign in_ready_o = s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_en) begin
      s0_x_q    <= flip_x_val;
      s0_y_q    <= flip_y_val;
      s0_pres_q <= in_item_i.pad_present;
    end
  end

  // Squared length, aligned so the root comes out in Q1.30.
  logic signed [2*W-1:0] x_sq, y_sq;
  logic [2*W-1:0]        len_sq;
  logic [RAD_W-1:0]      rad;
  sqrt_tag_t             sq_tag_in, sq_tag_out;

  assign x_sq      = s0_x_q * s0_x_q;
  assign y_sq      = s0_y_q * s0_y_q;
  assign len_sq    = $unsigned(x_sq) + $unsigned(y_sq);
  assign rad       = {len_sq, {(RAD_W-2*W){1'b0}}};
  assign sq_tag_in = '{present: s0_pres_q, x: s0_x_q, y: s0_y_q};

  logic              sqrt_out_valid;
  logic              div1_in_ready;
  logic [ROOT_W-1:0] mag;

  srd_sqrt #(
    .ROOT_W_P (ROOT_W),
    .STEPS    (SQRT_STEPS),
    .TAG_W    ($bits(sqrt_tag_t))
  ) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_vld_q),
    .in_ready_o  (sqrt_in_ready),
    .rad_i       (rad),
    .tag_i       (sq_tag_in),
    .out_valid_o (sqrt_out_valid),
    .out_ready_i (div1_in_ready),
    .root_o      (mag),
    .tag_o       (sq_tag_out)
  );

  // Deadzone test and remap operands (m - d) / (1 - d).
  logic [ROOT_W-1:0] dead_q30, rm_num, rm_den, rm_hi;
  logic              rm_zero, rm_sat;
  remap_tag_t        rm_tag_in, rm_tag_out;

  assign dead_q30 = {1'b0, dead_q, {DEAD_SHIFT{1'b0}}};
  assign rm_zero  = !sq_tag_out.present || (mag < dead_q30) || (mag == '0);
  assign rm_num   = mag - dead_q30;
  assign rm_den   = ONE_Q30 - dead_q30;
  assign rm_sat   = rm_num >= rm_den;
  assign rm_hi    = rm_sat ? '0 : rm_num;
  assign rm_tag_in = '{zero: rm_zero, sat: rm_sat, x: sq_tag_out.x, y: sq_tag_out.y};

  logic              div1_out_valid;
  logic              mul_en;
  logic [ROOT_W-2:0] remap_q;
  logic [ROOT_W-1:0] mag_d1;

  srd_div #(
    .LANES (1),
    .DEN_W (ROOT_W),
    .QW    (ROOT_W - 1),
    .STEPS (DIV_STEPS),
    .TAG_W ($bits(remap_tag_t) + ROOT_W)
  ) u_remap_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sqrt_out_valid),
    .in_ready_o  (div1_in_ready),
    .den_i       (rm_den),
    .hi_i        (rm_hi),
    .lo_i        ('0),
    .tag_i       ({rm_tag_in, mag}),
    .out_valid_o (div1_out_valid),
    .out_ready_i (mul_en),
    .quot_o      (remap_q),
    .tag_o       ({rm_tag_out, mag_d1})
  );

  // Multiply stage: |axis| times the clamped remapped magnitude.
  logic [ROOT_W-1:0]   remap_n;
  logic [W-1:0]        abs_x, abs_y;
  logic [W+ROOT_W-1:0] prod_x, prod_y;
  logic                mul_vld_q;
  logic [W+ROOT_W-1:0] prod_x_q, prod_y_q;
  logic [ROOT_W-1:0]   mul_mag_q;
  scale_tag_t          mul_tag_q;
  logic                div2_in_ready;

  assign remap_n = rm_tag_out.sat ? ONE_Q30 : {1'b0, remap_q};
  assign abs_x   = rm_tag_out.x[W-1] ? (~rm_tag_out.x + 1'b1) : rm_tag_out.x;
  assign abs_y   = rm_tag_out.y[W-1] ? (~rm_tag_out.y + 1'b1) : rm_tag_out.y;
  assign prod_x  = {{ROOT_W{1'b0}}, abs_x} * {{W{1'b0}}, remap_n};
  assign prod_y  = {{ROOT_W{1'b0}}, abs_y} * {{W{1'b0}}, remap_n};
  assign mul_en  = !mul_vld_q || div2_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (mul_en) begin
      mul_vld_q <= div1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_x_q  <= prod_x;
      prod_y_q  <= prod_y;
      mul_mag_q <= mag_d1;
      mul_tag_q <= '{zero: rm_tag_out.zero, neg_x: rm_tag_out.x[W-1],
                     neg_y: rm_tag_out.y[W-1]};
    end
  end

  // Rounded scale division by the magnitude, both axes sharing the divisor.
  logic [W+ROOT_W:0]   dvd_x, dvd_y;
  logic [W+ROOT_W:0]   half_mag;
  logic                div2_out_valid;
  logic                out_en;
  logic [1:0][W:0]     scale_q;
  scale_tag_t          d2_tag;

  assign half_mag = {{(W+2){1'b0}}, mul_mag_q[ROOT_W-1:1]};
  assign dvd_x    = {1'b0, prod_x_q} + half_mag;
  assign dvd_y    = {1'b0, prod_y_q} + half_mag;

  srd_div #(
    .LANES (2),
    .DEN_W (ROOT_W),
    .QW    (W + 1),
    .STEPS (DIV_STEPS),
    .TAG_W ($bits(scale_tag_t))
  ) u_scale_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_vld_q),
    .in_ready_o  (div2_in_ready),
    .den_i       (mul_mag_q),
    .hi_i        ({dvd_y[W+ROOT_W:W+1], dvd_x[W+ROOT_W:W+1]}),
    .lo_i        ({dvd_y[W:0], dvd_x[W:0]}),
    .tag_i       (mul_tag_q),
    .out_valid_o (div2_out_valid),
    .out_ready_i (out_en),
    .quot_o      (scale_q),
    .tag_o       (d2_tag)
  );

  // Output stage: saturate, restore sign, and force zero in the deadzone or for an absent pad.
  logic signed [W-1:0] mag_x, mag_y, res_x, res_y;
  logic                out_vld_q;
  out_item_t           out_item_q;

  always_comb begin
    mag_x = (scale_q[0] > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : scale_q[0][W-1:0];
    mag_y = (scale_q[1] > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : scale_q[1][W-1:0];
    res_x = d2_tag.neg_x ? -mag_x : mag_x;
    res_y = d2_tag.neg_y ? -mag_y : mag_y;
    if (d2_tag.zero) begin
      res_x = '0;
      res_y = '0;
    end
  end

  assign out_en = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= div2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_item_q <= '{out_y: res_y, out_x: res_x};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // A free output register means every stage upstream can move.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the output side can move");

  // Deadzone and absent-pad results leave as exact zeros.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div2_out_valid && out_en && d2_tag.zero) |=>
      (out_item_o.out_x == '0 && out_item_o.out_y == '0))
    else $error("result inside deadzone is not zero");

  // Full-scale negative never leaves the block.
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_x != SAMPLE_MIN && out_item_o.out_y != SAMPLE_MIN))
    else $error("output reached the negative full-scale code");

endmodule
